FILE: src/cese_pkg.sv
// ----------------------------------------------------------------------------
// cese_pkg
// Shared types, codes and helpers of the carriage encoder and sensor emulator.
// ----------------------------------------------------------------------------
package cese_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MACHINE_MODEL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CARRIAGE_KIND  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BELT_SHIFTED   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_COUNT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SOLENOID_COUNT = 3'd4;

  // Command codes.
  localparam logic [1:0] CMD_LEFT  = 2'd0;
  localparam logic [1:0] CMD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  // Machine models and carriage kinds.
  localparam logic [1:0] MODEL_FIRST  = 2'd0;
  localparam logic [1:0] MODEL_SECOND = 2'd1;
  localparam logic [1:0] MODEL_SMALL  = 2'd2;

  localparam logic [1:0] KIND_KNIT   = 2'd0;
  localparam logic [1:0] KIND_LACE   = 2'd1;
  localparam logic [1:0] KIND_GARTER = 2'd2;
  localparam logic [1:0] KIND_SMALL  = 2'd3;

  // Mechanical constants.
  localparam int MARGIN       = 32;
  localparam int BELT_ADVANCE = 2;

  localparam logic signed [10:0] POS_LO      = 11'(-MARGIN);
  localparam logic signed [10:0] POS_HI_BIAS = 11'(MARGIN - 1);

  // Hall sensor readings.
  localparam logic [11:0] HALL_IDLE  = 12'd1650;
  localparam logic [11:0] HALL_NORTH = 12'd2200;
  localparam logic [11:0] HALL_SOUTH = 12'd100;
  localparam logic [11:0] HALL_LOW   = 12'd0;

  typedef struct packed {
    logic [1:0] machine_model;
    logic [1:0] carriage_kind;
    logic       belt_shifted;
    logic [7:0] needle_count;
    logic [4:0] solenoid_count;
  } cfg_t;

  // One classified command as it waits between front and back.
  typedef struct packed {
    logic              step_left;
    logic              step_right;
    logic              load;
    logic [15:0]       solenoid_word;
    logic signed [9:0] load_position;
  } item_t;

  typedef struct packed {
    logic              enc_v1;
    logic              enc_v2;
    logic              belt_sync;
    logic [11:0]       left_hall;
    logic [11:0]       right_hall;
    logic signed [9:0] position;
    logic [5:0]        phase;
    logic              needle_valid;
    logic [7:0]        needle_index;
    logic              needle_pushed;
  } result_t;

  // Quadrature code of the low two phase bits: 0, 1, 3, 2.
  function automatic logic [1:0] quad_code(input logic [1:0] p);
    logic [1:0] c;
    unique case (p)
      2'd0: c = 2'b00;
      2'd1: c = 2'b01;
      2'd2: c = 2'b11;
      2'd3: c = 2'b10;
    endcase
    return c;
  endfunction

  // One restoring step of a remainder: subtract div shifted by k if it fits.
  function automatic logic [8:0] mod_step(input logic [8:0] rem, input logic [6:0] div,
                                          input logic [3:0] k);
    logic [15:0] shifted;
    logic [15:0] wide;
    shifted = {9'd0, div} << k;
    wide    = {7'd0, rem};
    if (wide >= shifted) begin
      return 9'(wide - shifted);
    end
    return rem;
  endfunction

endpackage

FILE: src/carriage_encoder_sensor_emulator.sv
// ----------------------------------------------------------------------------
// carriage_encoder_sensor_emulator
// Carriage, encoder and hall sensor emulation for a needle bed, one result
// per command, with a decoupled command front and execution back.
// ----------------------------------------------------------------------------
//
//   channel   handshake            beat contents
//   -------   ------------------   ----------------------------------------------
//   in_       in_push / in_full    command, solenoid word, load position
//   out_      out_pop / out_empty  encoder pair, belt phase, halls, position,
//                                  phase, needle selection
//   cfg_      cfg_we               register index and data, no read-back
//
// The back end takes one command at a time: the phase and position step,
// the hall lookup and the needle selection, then two restoring modulo
// chains (three bit steps per cycle; a full result queue holds the pass at its end)
// that reduce the solenoid index and the belt phase. A beat pushed into an
// empty block passes the command queue and these steps into the result queue.
// Reset (rst_n low, synchronous) empties both queues, zeroes phase and
// position and loads the default configuration.
// A full result queue stalls only the back end; the input queue keeps
// accepting until it fills too.
//
module carriage_encoder_sensor_emulator #(
  parameter int QUEUE_DEPTH = 2,
  parameter int OUT_DEPTH   = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [cese_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cese_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Command channel.
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [1:0]                          in_command,
  input  logic [15:0]                         in_solenoid_word,
  input  logic signed [9:0]                   in_load_position,
  // Result channel.
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_enc_v1,
  output logic                                out_enc_v2,
  output logic                                out_belt_sync,
  output logic [11:0]                         out_left_hall,
  output logic [11:0]                         out_right_hall,
  output logic signed [9:0]                   out_position,
  output logic [5:0]                          out_phase,
  output logic                                out_needle_valid,
  output logic [7:0]                          out_needle_index,
  output logic                                out_needle_pushed
);

  import cese_pkg::*;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(result_t);

  cfg_t cfg_r, cfg_nxt;

  item_t             f_item, q_head;
  logic              q_push, q_full, q_empty, q_pop;
  logic [ITEM_W-1:0] q_rdata;

  result_t          b_res, o_res;
  logic             res_push, res_full;
  logic [RES_W-1:0] o_rdata;

  // Configuration registers. Only the bits each register holds are kept;
  // writes to indexes beyond the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MACHINE_MODEL:  cfg_nxt.machine_model  = cfg_data[1:0];
        REG_CARRIAGE_KIND:  cfg_nxt.carriage_kind  = cfg_data[1:0];
        REG_BELT_SHIFTED:   cfg_nxt.belt_shifted   = cfg_data[0];
        REG_NEEDLE_COUNT:   cfg_nxt.needle_count   = cfg_data[7:0];
        REG_SOLENOID_COUNT: cfg_nxt.solenoid_count = cfg_data[4:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.machine_model  <= MODEL_FIRST;
      cfg_r.carriage_kind  <= KIND_KNIT;
      cfg_r.belt_shifted   <= 1'b0;
      cfg_r.needle_count   <= 8'd200;
      cfg_r.solenoid_count <= 5'd16;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: decode and saturate, straight into the command queue.
  cese_front u_front (
    .cfg              (cfg_r),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_solenoid_word (in_solenoid_word),
    .in_load_position (in_load_position),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_item           (f_item)
  );

  cese_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_head = item_t'(q_rdata);

  // Back: owns the phase and position state.
  cese_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_item   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res      (b_res),
    .res_push (res_push),
    .res_full (res_full)
  );

  // Result queue parts the back end from the consumer.
  cese_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (b_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (o_rdata),
    .empty (out_empty)
  );

  assign o_res             = result_t'(o_rdata);
  assign out_enc_v1        = o_res.enc_v1;
  assign out_enc_v2        = o_res.enc_v2;
  assign out_belt_sync     = o_res.belt_sync;
  assign out_left_hall     = o_res.left_hall;
  assign out_right_hall    = o_res.right_hall;
  assign out_position      = o_res.position;
  assign out_phase         = o_res.phase;
  assign out_needle_valid  = o_res.needle_valid;
  assign out_needle_index  = o_res.needle_index;
  assign out_needle_pushed = o_res.needle_pushed;

endmodule

FILE: src/cese_fifo.sv
// ----------------------------------------------------------------------------
// cese_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cese_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             wr, rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r + CW'(wr) - CW'(rd);
    if (wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: src/cese_front.sv
// ----------------------------------------------------------------------------
// cese_front
// Accepts commands, decodes them and saturates load positions to the bed.
// ----------------------------------------------------------------------------
module cese_front (
  input  cese_pkg::cfg_t   cfg,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_command,
  input  logic [15:0]      in_solenoid_word,
  input  logic signed [9:0] in_load_position,
  output logic             q_push,
  input  logic             q_full,
  output cese_pkg::item_t  q_item
);

  import cese_pkg::*;

  logic signed [10:0] pos_hi;
  logic signed [10:0] ld_wide;
  logic signed [10:0] ld_sat;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign pos_hi  = $signed({3'b000, cfg.needle_count}) + POS_HI_BIAS;
  assign ld_wide = {in_load_position[9], in_load_position};

  // Upper bound first, then lower, so the lower margin wins if the bounds cross.
  always_comb begin
    ld_sat = ld_wide;
    if (ld_sat > pos_hi) begin
      ld_sat = pos_hi;
    end
    if (ld_sat < POS_LO) begin
      ld_sat = POS_LO;
    end
  end

  always_comb begin
    q_item               = '0;
    q_item.solenoid_word = in_solenoid_word;
    q_item.load_position = ld_sat[9:0];
    unique case (in_command)
      CMD_LEFT:  q_item.step_left  = 1'b1;
      CMD_RIGHT: q_item.step_right = 1'b1;
      CMD_LOAD:  q_item.load       = 1'b1;
      default:   ;
    endcase
  end

endmodule

FILE: src/cese_back.sv
// ----------------------------------------------------------------------------
// cese_back
// Executes one command: phase and position update, hall readings, needle
// selection, then an iterative modulo for the solenoid and belt phase.
// ----------------------------------------------------------------------------
module cese_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cese_pkg::cfg_t    cfg,
  input  cese_pkg::item_t   q_item,
  input  logic              q_empty,
  output logic              q_pop,
  output cese_pkg::result_t res,
  output logic              res_push,
  input  logic              res_full
);

  import cese_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_MOD  = 1'b1;
  localparam logic [1:0] LAST_CNT = 2'd2;

  localparam logic signed [10:0] GARTER_L_SOUTH = 11'sd12;
  localparam logic signed [10:0] GARTER_L_NORTH = 11'sd10;
  localparam logic signed [10:0] GARTER_R_SOUTH_A = 11'sd187;
  localparam logic signed [10:0] GARTER_R_SOUTH_B = 11'sd211;
  localparam logic signed [10:0] GARTER_R_NORTH_A = 11'sd189;
  localparam logic signed [10:0] GARTER_R_NORTH_B = 11'sd209;
  localparam logic signed [10:0] SMALL_L_NORTH  = -11'sd6;
  localparam logic signed [10:0] SMALL_R_NORTH_A = 11'sd111;
  localparam logic signed [10:0] SMALL_R_NORTH_B = 11'sd117;
  localparam logic signed [10:0] OFF_KNIT  = 11'sd24;
  localparam logic signed [10:0] OFF_LACE  = 11'sd12;
  localparam logic signed [10:0] OFF_SMALL = 11'sd15;

  logic              state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [5:0]        phase_r, phase_nxt;
  logic signed [9:0] pos_r, pos_nxt;
  result_t           part_r, part_nxt;
  logic [8:0]        rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  logic [4:0]        s_r, s_nxt;
  logic              small_r, small_nxt;
  logic [15:0]       sol_r, sol_nxt;

  // Step stage signals.
  logic [4:0]         s_eff;
  logic [3:0]         half;
  logic signed [10:0] n_s, pos_hi, cur, new_pos, offset, sel;
  logic [5:0]         new_ph, ph_dn, ph_up;
  logic [11:0]        hl, hr;
  logic               first_model, sel_ok;
  logic [8:0]         sel9, div_a0, div_b0;
  logic [1:0]         code;

  // Modulo stage signals.
  logic [3:0]  kbase;
  logic [8:0]  a1, a2, a3, b1, b2, b3;
  logic [5:0]  sidx;
  logic        last;

  assign s_eff       = (cfg.solenoid_count == 5'd0) ? 5'd1 : cfg.solenoid_count;
  assign half        = s_eff[4:1];
  assign n_s         = $signed({3'b000, cfg.needle_count});
  assign pos_hi      = n_s + POS_HI_BIAS;
  assign cur         = {pos_r[9], pos_r};
  assign ph_dn       = phase_r - 6'd1;
  assign ph_up       = phase_r + 6'd1;
  assign first_model = (cfg.machine_model == MODEL_FIRST);

  always_comb begin
    new_ph  = phase_r;
    new_pos = cur;
    priority if (q_item.step_left) begin
      new_ph = ph_dn;
      if (ph_dn[1:0] == 2'd3) begin
        if (cur > POS_LO) begin
          new_pos = cur - 11'sd1;
        end else begin
          new_pos = POS_LO;
          new_ph  = phase_r;
        end
      end
    end else if (q_item.step_right) begin
      new_ph = ph_up;
      if (ph_up[1:0] == 2'd0) begin
        if (cur < pos_hi) begin
          new_pos = cur + 11'sd1;
        end else begin
          new_pos = pos_hi;
          new_ph  = phase_r;
        end
      end
    end else if (q_item.load) begin
      new_pos = {q_item.load_position[9], q_item.load_position};
    end
  end

  always_comb begin
    hl     = HALL_IDLE;
    hr     = HALL_IDLE;
    offset = 11'sd0;
    unique case (cfg.carriage_kind)
      KIND_KNIT: begin
        if (new_pos == 11'sd0) begin
          hl = HALL_NORTH;
        end else if (new_pos == n_s - 11'sd1) begin
          hr = first_model ? HALL_LOW : HALL_NORTH;
        end
        offset = q_item.step_right ? -OFF_KNIT : OFF_KNIT;
      end
      KIND_LACE: begin
        if (new_pos == 11'sd0) begin
          hl = HALL_SOUTH;
        end else if (new_pos == n_s - 11'sd1) begin
          hr = first_model ? HALL_IDLE : HALL_SOUTH;
        end
        offset = q_item.step_right ? -OFF_LACE : OFF_LACE;
      end
      KIND_GARTER: begin
        if (new_pos == GARTER_L_SOUTH || new_pos == -GARTER_L_SOUTH) begin
          hl = HALL_SOUTH;
        end else if (new_pos == GARTER_L_NORTH || new_pos == -GARTER_L_NORTH) begin
          hl = HALL_NORTH;
        end else if (new_pos == GARTER_R_SOUTH_A || new_pos == GARTER_R_SOUTH_B) begin
          hr = first_model ? HALL_IDLE : HALL_SOUTH;
        end else if (new_pos == GARTER_R_NORTH_A || new_pos == GARTER_R_NORTH_B) begin
          hr = first_model ? HALL_LOW : HALL_NORTH;
        end
      end
      KIND_SMALL: begin
        if (new_pos == SMALL_L_NORTH || new_pos == 11'sd0) begin
          hl = HALL_NORTH;
        end else if (new_pos == SMALL_R_NORTH_A || new_pos == SMALL_R_NORTH_B) begin
          hr = HALL_NORTH;
        end
        offset = q_item.step_right ? -OFF_SMALL : OFF_SMALL;
      end
    endcase
  end

  assign sel    = new_pos + offset;
  assign sel_ok = (sel >= 11'sd0) && (sel < n_s);
  assign sel9   = {1'b0, sel[7:0]};
  assign code   = quad_code(new_ph[1:0]);
  assign div_b0 = {3'b000, new_ph} + 9'(BELT_ADVANCE);

  always_comb begin
    if (cfg.machine_model == MODEL_SMALL) begin
      div_a0 = sel9 + 9'd4 + (q_item.step_left ? {5'd0, half} : 9'd0);
    end else begin
      div_a0 = sel9 + (cfg.belt_shifted ? {5'd0, half} : 9'd0)
             + ((cfg.carriage_kind == KIND_LACE && q_item.step_left) ? {5'd0, half} : 9'd0);
    end
  end

  // Three restoring steps per cycle; the steps run over bit weights 8 down to 0.
  always_comb begin
    unique case (cnt_r)
      2'd0:    kbase = 4'd8;
      2'd1:    kbase = 4'd5;
      default: kbase = 4'd2;
    endcase
  end

  assign a1 = mod_step(rem_a_r, {2'b00, s_r}, kbase);
  assign a2 = mod_step(a1, {2'b00, s_r}, kbase - 4'd1);
  assign a3 = mod_step(a2, {2'b00, s_r}, kbase - 4'd2);
  assign b1 = mod_step(rem_b_r, {s_r, 2'b00}, kbase);
  assign b2 = mod_step(b1, {s_r, 2'b00}, kbase - 4'd1);
  assign b3 = mod_step(b2, {s_r, 2'b00}, kbase - 4'd2);

  assign sidx = small_r ? 6'd3 + {1'b0, a3[4:0]} : {1'b0, a3[4:0]};

  always_comb begin
    res            = part_r;
    res.belt_sync  = (b3 > {3'b000, s_r, 1'b0}) ? 1'b0 : 1'b1;
    res.needle_pushed = part_r.needle_valid
                      && ((sidx[5:4] != 2'b00) || !sol_r[sidx[3:0]]);
  end

  assign last     = (state_r == S_MOD) && (cnt_r == LAST_CNT);
  assign res_push = last && !res_full;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    part_nxt  = part_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    s_nxt     = s_r;
    small_nxt = small_r;
    sol_nxt   = sol_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          phase_nxt             = new_ph;
          pos_nxt               = new_pos[9:0];
          part_nxt              = '0;
          part_nxt.enc_v1       = code[1];
          part_nxt.enc_v2       = code[0];
          part_nxt.left_hall    = hl;
          part_nxt.right_hall   = hr;
          part_nxt.position     = new_pos[9:0];
          part_nxt.phase        = new_ph;
          part_nxt.needle_valid = sel_ok;
          part_nxt.needle_index = sel_ok ? sel[7:0] : 8'd0;
          rem_a_nxt             = div_a0;
          rem_b_nxt             = div_b0;
          s_nxt                 = s_eff;
          small_nxt             = (cfg.machine_model == MODEL_SMALL);
          sol_nxt               = q_item.solenoid_word;
          cnt_nxt               = 2'd0;
          state_nxt             = S_MOD;
        end
      end
      S_MOD: begin
        if (cnt_r != LAST_CNT) begin
          rem_a_nxt = a3;
          rem_b_nxt = b3;
          cnt_nxt   = cnt_r + 2'd1;
        end else if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
      phase_r <= 6'd0;
      pos_r   <= 10'sd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r  <= part_nxt;
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
    s_r     <= s_nxt;
    small_r <= small_nxt;
    sol_r   <= sol_nxt;
  end

  // A command taken from the queue always starts the modulo pass.
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_MOD) && (cnt_r == 2'd0))
    else $error("queue pop did not start the modulo pass");

  // Results leave only at the end of the modulo pass.
  a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (state_r == S_MOD) && (cnt_r == LAST_CNT))
    else $error("result pushed before the modulo pass ended");

  // The carriage never passes the left margin.
  a_pos_floor: assert property (@(posedge clk) disable iff (!rst_n)
    $signed({pos_r[9], pos_r}) >= POS_LO)
    else $error("carriage position below left margin");

  // Phase moves by at most one per command and only when one is taken.
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> $stable(phase_r))
    else $error("phase changed without a command");

endmodule
